>>> rtl/tcp_connection_state_tracker_assert.svh
// assertion macros shared by the connection tracker rtl
`ifndef TCP_CONNECTION_STATE_TRACKER_ASSERT_SVH
`define TCP_CONNECTION_STATE_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcst assertion failed");

// antecedent implies consequent in the next cycle
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcst assertion failed");

`endif

>>> rtl/tcst_pkg.sv
// types, codes and state encoding helpers for the connection tracker
package tcst_pkg;

	// connection states, one-hot
	typedef enum logic [10:0] {
		ST_CLOSED     = 11'b000_0000_0001,
		ST_LISTEN     = 11'b000_0000_0010,
		ST_SYN_SENT   = 11'b000_0000_0100,
		ST_SYN_RCVD   = 11'b000_0000_1000,
		ST_ESTAB      = 11'b000_0001_0000,
		ST_FIN_WAIT1  = 11'b000_0010_0000,
		ST_FIN_WAIT2  = 11'b000_0100_0000,
		ST_CLOSE_WAIT = 11'b000_1000_0000,
		ST_CLOSING    = 11'b001_0000_0000,
		ST_LAST_ACK   = 11'b010_0000_0000,
		ST_TIME_WAIT  = 11'b100_0000_0000
	} conn_st_t;

	// item modes
	typedef enum logic [1:0] {
		MODE_SEGMENT = 2'd0,
		MODE_OPEN    = 2'd1,
		MODE_LOAD    = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// bit positions in the tcp flag byte
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_ACK = 4;

	// register index taken from paddr[2]
	localparam logic REG_ROLE = 1'b0;
	localparam logic REG_ISS  = 1'b1;
	localparam int   ADDR_W   = 3;

	// per-connection tracking state
	typedef struct packed {
		conn_st_t    st;
		logic [31:0] ack_value;
		logic [31:0] peer_next;
		logic [31:0] peer_initial;
	} ctx_t;

	// one input item
	typedef struct packed {
		mode_t       mode;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [7:0]  seg_flags;
		logic [3:0]  forced_state;
	} item_t;

	// external 4-bit state code to one-hot, out of range codes map to closed
	function automatic conn_st_t decode_state(input logic [3:0] code);
		conn_st_t st;
		unique case (code)
			4'd0:    st = ST_CLOSED;
			4'd1:    st = ST_LISTEN;
			4'd2:    st = ST_SYN_SENT;
			4'd3:    st = ST_SYN_RCVD;
			4'd4:    st = ST_ESTAB;
			4'd5:    st = ST_FIN_WAIT1;
			4'd6:    st = ST_FIN_WAIT2;
			4'd7:    st = ST_CLOSE_WAIT;
			4'd8:    st = ST_CLOSING;
			4'd9:    st = ST_LAST_ACK;
			4'd10:   st = ST_TIME_WAIT;
			default: st = ST_CLOSED;
		endcase
		return st;
	endfunction

	// one-hot state to external 4-bit code
	function automatic logic [3:0] encode_state(input conn_st_t st);
		logic [3:0] code;
		unique case (st)
			ST_CLOSED:     code = 4'd0;
			ST_LISTEN:     code = 4'd1;
			ST_SYN_SENT:   code = 4'd2;
			ST_SYN_RCVD:   code = 4'd3;
			ST_ESTAB:      code = 4'd4;
			ST_FIN_WAIT1:  code = 4'd5;
			ST_FIN_WAIT2:  code = 4'd6;
			ST_CLOSE_WAIT: code = 4'd7;
			ST_CLOSING:    code = 4'd8;
			ST_LAST_ACK:   code = 4'd9;
			ST_TIME_WAIT:  code = 4'd10;
			default:       code = 4'd0;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/tcst_in_if.sv
// input channel: segment, open or forced load items
interface tcst_in_if;
	logic                valid;
	logic                ready;
	tcst_pkg::mode_t     mode;
	logic [31:0]         seg_seq;
	logic [31:0]         seg_ack;
	logic [7:0]          seg_flags;
	logic [3:0]          forced_state;

	modport source (output valid, mode, seg_seq, seg_ack, seg_flags, forced_state,
		input ready);
	modport sink (input valid, mode, seg_seq, seg_ack, seg_flags, forced_state,
		output ready);
endinterface

>>> rtl/tcst_out_if.sv
// result channel: connection state and reply information
interface tcst_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  conn_state;
	logic        reply_needed;
	logic [31:0] ack_to_send;
	logic [31:0] peer_next_seq;
	logic [31:0] peer_initial_seq;

	modport source (output valid, conn_state, reply_needed, ack_to_send, peer_next_seq,
		peer_initial_seq, input ready);
	modport sink (input valid, conn_state, reply_needed, ack_to_send, peer_next_seq,
		peer_initial_seq, output ready);
endinterface

>>> rtl/tcp_connection_state_tracker.sv
// top level of the single-connection tcp state tracker
//
// Items arrive on req (valid/ready): a received segment, an open event or a
// forced state load. Each accepted item gives exactly one result on rsp
// (valid/ready) with the state, reply flag and sequence values after update.
// An item is taken into an input register; the combinational next-state logic
// then writes the tracking registers and the result register together, and rsp
// valid is driven from the result register. One item per cycle is sustained
// while rsp takes every result; the tracking registers are the only loop.
// The block keeps taking items while a result waits, as long as the input
// register can drain; when rsp stalls, the result holds and req deasserts
// ready once the input register is also full.
// Registers role_server (addr 0) and initial_send_seq (addr 4) are written
// over the apb port; the user must do so only while no item is in flight,
// as the block does not enforce it. Reset clears the configuration and
// tracking registers and the valid flags, and puts the connection in CLOSED
// with all sequence values zero; no clearing pass is needed.
`include "tcp_connection_state_tracker_assert.svh"

module tcp_connection_state_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	tcst_in_if.sink                     req,
	tcst_out_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic              role_q;
	logic [31:0]       iss_q;
	logic              valid_s1;
	tcst_pkg::item_t   item_s1;
	logic              adv;
	tcst_pkg::ctx_t    ctx_q;
	tcst_pkg::ctx_t    ctx_nxt;
	logic              reply_nxt;
	logic              out_valid_q;
	logic [3:0]        out_state_q;
	logic              out_reply_q;
	logic [31:0]       out_ack_q;
	logic [31:0]       out_next_q;
	logic [31:0]       out_init_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= 1'b0;
			iss_q  <= 32'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				tcst_pkg::REG_ROLE: role_q <= pwdata[0];
				tcst_pkg::REG_ISS:  iss_q  <= pwdata;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tcst_pkg::REG_ISS) ? iss_q : {31'd0, role_q};

	// handshake: input stage moves when the result register is free or drains
	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.mode         <= req.mode;
			item_s1.seg_seq      <= req.seg_seq;
			item_s1.seg_ack      <= req.seg_ack;
			item_s1.seg_flags    <= req.seg_flags;
			item_s1.forced_state <= req.forced_state;
		end
	end

	// connection next-state logic
	tcst_next u_next (
		.cur              (ctx_q),
		.item             (item_s1),
		.role_server      (role_q),
		.initial_send_seq (iss_q),
		.nxt              (ctx_nxt),
		.reply_needed     (reply_nxt)
	);

	// tracking registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.st           <= tcst_pkg::ST_CLOSED;
			ctx_q.ack_value    <= 32'd0;
			ctx_q.peer_next    <= 32'd0;
			ctx_q.peer_initial <= 32'd0;
		end else if (adv) begin
			ctx_q <= ctx_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_state_q <= tcst_pkg::encode_state(ctx_nxt.st);
			out_reply_q <= reply_nxt;
			out_ack_q   <= ctx_nxt.ack_value;
			out_next_q  <= ctx_nxt.peer_next;
			out_init_q  <= ctx_nxt.peer_initial;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.conn_state       = out_state_q;
	assign rsp.reply_needed     = out_reply_q;
	assign rsp.ack_to_send      = out_ack_q;
	assign rsp.peer_next_seq    = out_next_q;
	assign rsp.peer_initial_seq = out_init_q;

	// checks
	`TCST_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, out_valid_q)
	`TCST_ASSERT_SAME(a_ready_when_out_free, clk, arst_n, !out_valid_q, req.ready)
	`TCST_ASSERT_NEXT(a_rst_closes, clk, arst_n,
		adv && (item_s1.mode == tcst_pkg::MODE_SEGMENT) && item_s1.seg_flags[tcst_pkg::FLAG_RST],
		(ctx_q.st == tcst_pkg::ST_CLOSED) && !out_reply_q)
	`TCST_ASSERT_NEXT(a_open_clears, clk, arst_n,
		adv && (item_s1.mode == tcst_pkg::MODE_OPEN),
		(ctx_q.ack_value == 32'd0) && (ctx_q.peer_initial == 32'd0) && !out_reply_q)

endmodule

>>> rtl/tcst_next.sv
// next-state logic of the connection machine for one item
module tcst_next (
	input  tcst_pkg::ctx_t  cur,
	input  tcst_pkg::item_t item,
	input  logic            role_server,
	input  logic [31:0]     initial_send_seq,
	output tcst_pkg::ctx_t  nxt,
	output logic            reply_needed
);

	logic        fin, syn, rst, ackf;
	logic [31:0] expect_ack;
	logic [31:0] seq_inc;
	logic        ack_ok;

	// flag decode and sequence arithmetic
	assign fin        = item.seg_flags[tcst_pkg::FLAG_FIN];
	assign syn        = item.seg_flags[tcst_pkg::FLAG_SYN];
	assign rst        = item.seg_flags[tcst_pkg::FLAG_RST];
	assign ackf       = item.seg_flags[tcst_pkg::FLAG_ACK];
	assign expect_ack = initial_send_seq + 32'd1;
	assign seq_inc    = item.seg_seq + 32'd1;
	assign ack_ok     = (item.seg_ack == expect_ack);

	// state transitions
	always_comb begin
		nxt          = cur;
		reply_needed = 1'b0;
		unique case (item.mode)
			tcst_pkg::MODE_SEGMENT: begin
				if (rst) begin
					nxt.st = tcst_pkg::ST_CLOSED;
				end else begin
					unique case (cur.st)
						tcst_pkg::ST_LISTEN: begin
							if (syn && !ackf) begin
								nxt.peer_initial = item.seg_seq;
								nxt.peer_next    = seq_inc;
								nxt.ack_value    = seq_inc;
								nxt.st           = tcst_pkg::ST_SYN_RCVD;
								reply_needed     = 1'b1;
							end
						end
						tcst_pkg::ST_SYN_SENT: begin
							if (syn && ackf) begin
								if (ack_ok) begin
									nxt.peer_initial = item.seg_seq;
									nxt.peer_next    = seq_inc;
									nxt.ack_value    = seq_inc;
									nxt.st           = tcst_pkg::ST_ESTAB;
									reply_needed     = 1'b1;
								end
							end else if (syn) begin
								nxt.peer_initial = item.seg_seq;
								nxt.peer_next    = seq_inc;
								nxt.ack_value    = seq_inc;
								nxt.st           = tcst_pkg::ST_SYN_RCVD;
								reply_needed     = 1'b1;
							end
						end
						tcst_pkg::ST_SYN_RCVD: begin
							if (ackf && ack_ok) begin
								nxt.st = tcst_pkg::ST_ESTAB;
							end
						end
						tcst_pkg::ST_ESTAB: begin
							if (fin) begin
								nxt.peer_next = seq_inc;
								nxt.ack_value = seq_inc;
								nxt.st        = tcst_pkg::ST_CLOSE_WAIT;
								reply_needed  = 1'b1;
							end else if (ackf) begin
								nxt.ack_value = item.seg_ack;
							end
						end
						tcst_pkg::ST_FIN_WAIT1: begin
							if (ackf) begin
								nxt.st = fin ? tcst_pkg::ST_CLOSING : tcst_pkg::ST_FIN_WAIT2;
							end
						end
						tcst_pkg::ST_FIN_WAIT2: begin
							if (fin) begin
								nxt.peer_next = seq_inc;
								nxt.ack_value = seq_inc;
								nxt.st        = tcst_pkg::ST_TIME_WAIT;
								reply_needed  = 1'b1;
							end
						end
						tcst_pkg::ST_CLOSING: begin
							if (ackf) begin
								nxt.st = tcst_pkg::ST_TIME_WAIT;
							end
						end
						tcst_pkg::ST_LAST_ACK: begin
							if (ackf) begin
								nxt.st = tcst_pkg::ST_CLOSED;
							end
						end
						tcst_pkg::ST_TIME_WAIT: begin
							nxt.st = tcst_pkg::ST_CLOSED;
						end
						// closed and close-wait ignore segments
						default: begin
						end
					endcase
				end
			end
			tcst_pkg::MODE_OPEN: begin
				nxt.st           = role_server ? tcst_pkg::ST_LISTEN : tcst_pkg::ST_SYN_SENT;
				nxt.ack_value    = 32'd0;
				nxt.peer_next    = 32'd0;
				nxt.peer_initial = 32'd0;
			end
			tcst_pkg::MODE_LOAD: begin
				nxt.st = tcst_pkg::decode_state(item.forced_state);
			end
			tcst_pkg::MODE_NONE: begin
			end
		endcase
	end

endmodule

>>> verif/tcst_tb_pkg.sv
// connection state codes shared by the tracker testbench
package tcst_tb_pkg;

	// external 4-bit state codes as seen on conn_state and forced_state
	typedef enum logic [3:0] {
		CS_CLOSED     = 4'd0,
		CS_LISTEN     = 4'd1,
		CS_SYN_SENT   = 4'd2,
		CS_SYN_RCVD   = 4'd3,
		CS_ESTAB      = 4'd4,
		CS_FIN_WAIT1  = 4'd5,
		CS_FIN_WAIT2  = 4'd6,
		CS_CLOSE_WAIT = 4'd7,
		CS_CLOSING    = 4'd8,
		CS_LAST_ACK   = 4'd9,
		CS_TIME_WAIT  = 4'd10
	} conn_code_t;

endpackage

>>> verif/tcst_conn_checker.sv
// checker: tracks the connection on every item transfer and compares each status result
module tcst_conn_checker
	import tcst_pkg::*;
	import tcst_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tcst_in_if                req,
	tcst_out_if               rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                mismatch_count,
	output int                status_pending
);

	typedef struct packed {
		conn_code_t  st;
		logic        reply;
		logic [31:0] ack_val;
		logic [31:0] peer_next;
		logic [31:0] peer_init;
	} conn_status_t;

	// tracked copy of the connection and its registers
	conn_code_t   cur_st;
	logic [31:0]  ack_val_m;
	logic [31:0]  peer_next_m;
	logic [31:0]  peer_init_m;
	logic         role_m;
	logic [31:0]  iss_m;

	conn_status_t status_due[$];
	conn_status_t want;
	conn_status_t got;
	int           errs;

	// peer syn seen: remember its sequence and expect the next one
	task automatic take_syn(input logic [31:0] seq);
		peer_init_m = seq;
		peer_next_m = seq + 32'd1;
		ack_val_m   = seq + 32'd1;
	endtask

	// apply one item to the tracked connection and queue the status it yields
	task automatic advance_connection(input mode_t m, input logic [31:0] seq,
		input logic [31:0] ack, input logic [7:0] fl, input logic [3:0] fs);
		conn_status_t s;
		logic fin, syn, rst, ackf, ack_ok, reply;
		fin    = fl[FLAG_FIN];
		syn    = fl[FLAG_SYN];
		rst    = fl[FLAG_RST];
		ackf   = fl[FLAG_ACK];
		ack_ok = (ack == iss_m + 32'd1);
		reply  = 1'b0;
		case (m)
			MODE_SEGMENT: begin
				if (rst) begin
					cur_st = CS_CLOSED;
				end else begin
					case (cur_st)
						CS_LISTEN: begin
							if (syn && !ackf) begin
								take_syn(seq);
								cur_st = CS_SYN_RCVD;
								reply  = 1'b1;
							end
						end
						CS_SYN_SENT: begin
							if (syn && ackf) begin
								if (ack_ok) begin
									take_syn(seq);
									cur_st = CS_ESTAB;
									reply  = 1'b1;
								end
							end else if (syn) begin
								take_syn(seq);
								cur_st = CS_SYN_RCVD;
								reply  = 1'b1;
							end
						end
						CS_SYN_RCVD: begin
							if (ackf && ack_ok)
								cur_st = CS_ESTAB;
						end
						CS_ESTAB: begin
							if (fin) begin
								peer_next_m = seq + 32'd1;
								ack_val_m   = seq + 32'd1;
								cur_st      = CS_CLOSE_WAIT;
								reply       = 1'b1;
							end else if (ackf) begin
								ack_val_m = ack;
							end
						end
						// fin with ack goes to closing, the plain ack to fin_wait2
						CS_FIN_WAIT1: begin
							if (ackf)
								cur_st = fin ? CS_CLOSING : CS_FIN_WAIT2;
						end
						CS_FIN_WAIT2: begin
							if (fin) begin
								peer_next_m = seq + 32'd1;
								ack_val_m   = seq + 32'd1;
								cur_st      = CS_TIME_WAIT;
								reply       = 1'b1;
							end
						end
						CS_CLOSING: begin
							if (ackf)
								cur_st = CS_TIME_WAIT;
						end
						CS_LAST_ACK: begin
							if (ackf)
								cur_st = CS_CLOSED;
						end
						CS_TIME_WAIT: begin
							cur_st = CS_CLOSED;
						end
						default: ;
					endcase
				end
			end
			MODE_OPEN: begin
				cur_st      = role_m ? CS_LISTEN : CS_SYN_SENT;
				ack_val_m   = 32'd0;
				peer_next_m = 32'd0;
				peer_init_m = 32'd0;
			end
			// codes past time_wait load closed
			MODE_LOAD: begin
				cur_st = (fs <= CS_TIME_WAIT) ? conn_code_t'(fs) : CS_CLOSED;
			end
			default: ;
		endcase
		s.st        = cur_st;
		s.reply     = reply;
		s.ack_val   = ack_val_m;
		s.peer_next = peer_next_m;
		s.peer_init = peer_init_m;
		status_due.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_st      = CS_CLOSED;
			ack_val_m   = 32'd0;
			peer_next_m = 32'd0;
			peer_init_m = 32'd0;
			role_m      = 1'b0;
			iss_m       = 32'd0;
			errs        = 0;
			status_due.delete();
			mismatch_count <= 0;
			status_pending <= 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_ROLE)
					role_m = pwdata[0];
				else
					iss_m = pwdata;
			end
			// result transfer against the oldest waiting status
			if (rsp.valid && rsp.ready) begin
				got.st        = conn_code_t'(rsp.conn_state);
				got.reply     = rsp.reply_needed;
				got.ack_val   = rsp.ack_to_send;
				got.peer_next = rsp.peer_next_seq;
				got.peer_init = rsp.peer_initial_seq;
				if (status_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected status at %0t: state %0d reply %0b ack %h next %h initial %h",
							$time, got.st, got.reply, got.ack_val, got.peer_next, got.peer_init);
				end else begin
					want = status_due.pop_front();
					if (got.st !== want.st || got.reply !== want.reply ||
						got.ack_val !== want.ack_val || got.peer_next !== want.peer_next ||
						got.peer_init !== want.peer_init) begin
						errs++;
						if (errs <= 10) begin
							$display("status mismatch at %0t: expected state %0d reply %0b ack %h next %h initial %h",
								$time, want.st, want.reply, want.ack_val, want.peer_next,
								want.peer_init);
							$display("  got state %0d reply %0b ack %h next %h initial %h",
								got.st, got.reply, got.ack_val, got.peer_next, got.peer_init);
						end
					end
				end
			end
			// item transfer
			if (req.valid && req.ready)
				advance_connection(req.mode, req.seg_seq, req.seg_ack, req.seg_flags,
					req.forced_state);
			mismatch_count <= errs;
			status_pending <= status_due.size();
		end
	end

endmodule

>>> verif/tb_tcp_connection_state_tracker.sv
// testbench top: clock, reset, segment stimulus, register writes and verdict
module tb_tcp_connection_state_tracker;
	import tcst_pkg::*;
	import tcst_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASES       = 8;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int          mismatch_count;
	int          status_pending;
	int          items_sent;
	int          cycles;
	int          stall_left;
	int          random_start;
	logic        tx_quiet;
	logic        rx_quiet;
	logic        role_cur;
	logic [31:0] iss_cur;

	tcst_in_if  req();
	tcst_out_if rsp();

	tcp_connection_state_tracker dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tcst_conn_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.status_pending (status_pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall after each transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = 0;
		end else if (rsp.valid && rsp.ready) begin
			stall_left = rx_quiet ? 0 : $urandom_range(0, 10);
			rsp.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= (stall_left == 0);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// one random bit
	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// sequence numbers with the wrap points weighted in
	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// flag byte with the named bits set as given, the unused bits random
	function automatic logic [7:0] seg_flags_of(input logic fin, input logic syn,
		input logic rst, input logic ackf);
		logic [7:0] f;
		f = 8'($urandom);
		f[FLAG_FIN] = fin;
		f[FLAG_SYN] = syn;
		f[FLAG_RST] = rst;
		f[FLAG_ACK] = ackf;
		return f;
	endfunction

	// one item transfer, after a random gap; valid stays high across back-to-back items
	task automatic send(input mode_t m, input logic [31:0] seq, input logic [31:0] ack,
		input logic [7:0] fl, input logic [3:0] fs);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.mode         <= m;
		req.seg_seq      <= seq;
		req.seg_ack      <= ack;
		req.seg_flags    <= fl;
		req.forced_state <= fs;
		do @(posedge clk); while (!req.ready);
		items_sent++;
	endtask

	// stop sending and wait for every outstanding status
	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (status_pending != 0);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// new role and initial send sequence, written while the tracker is idle
	task automatic configure(input logic role, input logic [31:0] iss);
		logic [31:0] w;
		settle();
		w = $urandom;
		w[0] = role;
		apb_write(REG_ROLE, w);
		apb_write(REG_ISS, iss);
		role_cur = role;
		iss_cur  = iss;
	endtask

	// mostly full connection lifetimes with random content, the rest noise
	task automatic run_scenario();
		logic [31:0] iss1;
		logic [7:0]  fl;
		logic        fin;
		mode_t       m;
		int          n;
		iss1 = iss_cur + 32'd1;
		if ($urandom_range(0, 39) == 0)
			settle();
		if ($urandom_range(0, 9) < 6) begin
			send(MODE_OPEN, rnd_word(), rnd_word(), 8'($urandom), 4'($urandom));
			// handshake for the configured role
			if (role_cur) begin
				send(MODE_SEGMENT, rnd_word(), rnd_word(),
					seg_flags_of(coin(), 1'b1, 1'b0, 1'b0), 4'($urandom));
			end else if ($urandom_range(0, 3) == 0) begin
				// simultaneous open
				send(MODE_SEGMENT, rnd_word(), rnd_word(),
					seg_flags_of(coin(), 1'b1, 1'b0, 1'b0), 4'($urandom));
			end else begin
				if ($urandom_range(0, 3) == 0)
					send(MODE_SEGMENT, rnd_word(), iss1 ^ (32'd1 << $urandom_range(0, 31)),
						seg_flags_of(coin(), 1'b1, 1'b0, 1'b1), 4'($urandom));
				send(MODE_SEGMENT, rnd_word(), iss1,
					seg_flags_of(coin(), 1'b1, 1'b0, 1'b1), 4'($urandom));
			end
			// final ack of the handshake when in syn_rcvd
			if (role_cur || $urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 3) == 0)
					send(MODE_SEGMENT, rnd_word(), iss1 ^ (32'd1 << $urandom_range(0, 31)),
						seg_flags_of(coin(), coin(), 1'b0, 1'b1),
						4'($urandom));
				send(MODE_SEGMENT, rnd_word(), iss1,
					seg_flags_of(coin(), coin(), 1'b0, 1'b1),
					4'($urandom));
			end
			// data acks
			n = $urandom_range(0, 4);
			repeat (n)
				send(MODE_SEGMENT, rnd_word(), rnd_word(),
					seg_flags_of(1'b0, coin(), 1'b0, 1'b1), 4'($urandom));
			// teardown
			case ($urandom_range(0, 3))
				0: begin
					send(MODE_SEGMENT, rnd_word(), rnd_word(),
						seg_flags_of(1'b1, coin(), 1'b0, coin()),
						4'($urandom));
					send(MODE_SEGMENT, rnd_word(), rnd_word(),
						seg_flags_of(coin(), coin(), 1'b0, coin()), 4'($urandom));
					send(MODE_LOAD, rnd_word(), rnd_word(), 8'($urandom), CS_LAST_ACK);
					if ($urandom_range(0, 1) == 0)
						send(MODE_SEGMENT, rnd_word(), rnd_word(),
							seg_flags_of(coin(), coin(), 1'b0, 1'b0),
							4'($urandom));
					send(MODE_SEGMENT, rnd_word(), rnd_word(),
						seg_flags_of(coin(), coin(), 1'b0, 1'b1),
						4'($urandom));
				end
				1: begin
					send(MODE_LOAD, rnd_word(), rnd_word(), 8'($urandom), CS_FIN_WAIT1);
					if ($urandom_range(0, 1) == 0)
						send(MODE_SEGMENT, rnd_word(), rnd_word(),
							seg_flags_of(coin(), coin(), 1'b0, 1'b0),
							4'($urandom));
					fin = coin();
					send(MODE_SEGMENT, rnd_word(), rnd_word(),
						seg_flags_of(fin, coin(), 1'b0, 1'b1), 4'($urandom));
					if (fin) begin
						send(MODE_SEGMENT, rnd_word(), rnd_word(),
							seg_flags_of(coin(), coin(), 1'b0, 1'b1),
							4'($urandom));
					end else begin
						if ($urandom_range(0, 1) == 0)
							send(MODE_SEGMENT, rnd_word(), rnd_word(),
								seg_flags_of(1'b0, coin(), 1'b0, coin()), 4'($urandom));
						send(MODE_SEGMENT, rnd_word(), rnd_word(),
							seg_flags_of(1'b1, coin(), 1'b0, coin()),
							4'($urandom));
					end
					send(MODE_SEGMENT, rnd_word(), rnd_word(), 8'($urandom), 4'($urandom));
				end
				2: send(MODE_SEGMENT, rnd_word(), rnd_word(),
					seg_flags_of(coin(), coin(), 1'b1, coin()), 4'($urandom));
				default: ;
			endcase
		end else begin
			// noise: any mode, loads into random states, mostly without reset flag
			n = $urandom_range(1, 6);
			repeat (n) begin
				fl = 8'($urandom);
				if ($urandom_range(0, 3) != 0)
					fl[FLAG_RST] = 1'b0;
				case ($urandom_range(0, 9))
					6:       m = MODE_OPEN;
					7, 8:    m = MODE_LOAD;
					9:       m = MODE_NONE;
					default: m = MODE_SEGMENT;
				endcase
				send(m, rnd_word(), ($urandom_range(0, 2) == 0) ? iss1 : rnd_word(), fl,
					4'($urandom));
			end
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		req.valid        <= 1'b0;
		req.mode         <= MODE_SEGMENT;
		req.seg_seq      <= 32'd0;
		req.seg_ack      <= 32'd0;
		req.seg_flags    <= 8'd0;
		req.forced_state <= 4'd0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= 32'd0;
		tx_quiet          = 1'b0;
		rx_quiet          = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// client role, initial sequence at the top so the expected ack wraps to zero
		configure(1'b0, 32'hFFFF_FFFF);
		send(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);
		send(MODE_OPEN, 32'd0, 32'd0, 8'h00, CS_CLOSED);
		send(MODE_SEGMENT, 32'h1234_5678, 32'd1, seg_flags_of(1'b0, 1'b1, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'hFFFF_FFFF, 32'd0, seg_flags_of(1'b0, 1'b1, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'hFFFF_FFFF, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'h7FFF_FFFF, 32'd0, seg_flags_of(1'b1, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b1, 1'b1, 1'b0, 1'b1), 4'd0);
		send(MODE_LOAD, 32'd0, 32'd0, 8'h00, 4'hF);
		send(MODE_LOAD, 32'd0, 32'd0, 8'h00, CS_LAST_ACK);
		send(MODE_SEGMENT, 32'd5, 32'd5, seg_flags_of(1'b1, 1'b1, 1'b0, 1'b0), 4'd0);
		send(MODE_SEGMENT, 32'd5, 32'd5, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);

		// server role, initial sequence zero
		configure(1'b1, 32'd0);
		send(MODE_OPEN, 32'd0, 32'd0, 8'h00, CS_CLOSED);
		send(MODE_SEGMENT, 32'd9, 32'd1, seg_flags_of(1'b0, 1'b1, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'hFFFF_FFFF, 32'd0, seg_flags_of(1'b0, 1'b1, 1'b0, 1'b0), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd1, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);
		// active close through closing and time_wait
		send(MODE_LOAD, 32'd0, 32'd0, 8'h00, CS_FIN_WAIT1);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b1, 1'b0, 1'b0, 1'b0), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b1, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'd0, 32'd0, 8'h00, 4'd0);
		// active close through fin_wait2
		send(MODE_LOAD, 32'd0, 32'd0, 8'h00, CS_FIN_WAIT1);
		send(MODE_SEGMENT, 32'd0, 32'd0, seg_flags_of(1'b0, 1'b0, 1'b0, 1'b1), 4'd0);
		send(MODE_SEGMENT, 32'hFFFF_FFFF, 32'd0, seg_flags_of(1'b1, 1'b0, 1'b0, 1'b0), 4'd0);
		// simultaneous open, then reset with every flag bit set
		send(MODE_LOAD, 32'd0, 32'd0, 8'h00, CS_SYN_SENT);
		send(MODE_SEGMENT, 32'h8000_0000, 32'd0, seg_flags_of(1'b0, 1'b1, 1'b0, 1'b0), 4'd0);
		send(MODE_SEGMENT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF);

		// random phases, each with its own register setting and idling mix
		random_start = items_sent;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(1'b0, 32'd0);
				1: configure(1'b1, 32'hFFFF_FFFF);
				default: configure(coin(), rnd_word());
			endcase
			tx_quiet = (p == 2) || ($urandom_range(0, 3) == 0);
			rx_quiet = (p == 2) || ($urandom_range(0, 3) == 0);
			while (items_sent < random_start + (p + 1) * (RANDOM_ITEMS / PHASES))
				run_scenario();
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/tcst_pkg.sv
rtl/tcst_in_if.sv
rtl/tcst_out_if.sv
rtl/tcst_next.sv
rtl/tcp_connection_state_tracker.sv
verif/tcst_tb_pkg.sv
verif/tcst_conn_checker.sv
verif/tb_tcp_connection_state_tracker.sv
